[src/mfq_pkg.sv]
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared types and constants of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int NUM_LEVELS_DEF  = 3;

   localparam logic [15:0] SLICE_LEN_RESET = 16'd2;
   localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

   // register index decoded from paddr[2]
   localparam logic CSR_IDX_SLICE = 1'b0;

   localparam logic ACT_ADMIT = 1'b0;
   localparam logic ACT_ROUND = 1'b1;

   typedef enum logic [1:0] {
      STAT_ADMITTED   = 2'd0,
      STAT_REJECTED   = 2'd1,
      STAT_DISPATCHED = 2'd2,
      STAT_IDLE       = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] rem;
      logic [15:0] dem;
   } job_type;

   typedef struct packed {
      logic [15:0] ran;
      logic [15:0] left;
      logic [15:0] dem;
      logic        done;
   } alu_res_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  served_id;
      logic [1:0]  level;
      logic [15:0] ran;
      logic [15:0] left;
      logic [15:0] demotions;
      logic        finished;
      logic        last;
   } rsp_type;

endpackage

[src/mfq_req_if.sv]
// ----------------------------------------------------------------------------
// mfq_req_if
// Request channel: admit a job or run one scheduling round.
// ----------------------------------------------------------------------------
interface mfq_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  job_id;
   logic [15:0] burst;

   modport source (output valid, action, job_id, burst, input ready);
   modport sink (input valid, action, job_id, burst, output ready);
endinterface

[src/mfq_rsp_if.sv]
// ----------------------------------------------------------------------------
// mfq_rsp_if
// Response channel: one beat per admit, per dispatch or per idle round.
// ----------------------------------------------------------------------------
interface mfq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  served_id;
   logic [1:0]  level;
   logic [15:0] ran;
   logic [15:0] left;
   logic [15:0] demotions;
   logic        finished;
   logic        last;

   modport source (output valid, status, served_id, level, ran, left, demotions,
                   finished, last, input ready);
   modport sink (input valid, status, served_id, level, ran, left, demotions,
                 finished, last, output ready);
endinterface

[src/multilevel_feedback_queue_scheduler.sv]
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Admit: job written at the tail of level 0 if room. Round: accept, then walk
//   the levels in order; each dispatch reads the ring, then subtracts and writes
//   back; next item taken when the last beat leaves. Reset clears pointers, counts, slice (2).
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler #(
   parameter int QUEUE_DEPTH = mfq_pkg::QUEUE_DEPTH_DEF,
   parameter int NUM_LEVELS  = mfq_pkg::NUM_LEVELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mfq_req_if.sink     req_chan,
   mfq_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mfq_pkg::*;

   localparam int IW        = $clog2(QUEUE_DEPTH);
   localparam int LW        = $clog2(NUM_LEVELS);
   localparam int AW        = IW + LW;
   localparam int MEM_DEPTH = NUM_LEVELS * (1 << IW);

   logic [15:0]  slice_len;
   logic         mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   job_type      mem_wr_data;
   logic         mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   job_type      mem_rd_data;
   alu_res_type  alu_res;
   rsp_type      rsp_data;

   mfq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .slice_len   (slice_len)
   );

   mfq_store #(
      .ADDR_W (AW),
      .DEPTH  (MEM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   mfq_alu u_alu (
      .slice_len (slice_len),
      .job       (mem_rd_data),
      .res       (alu_res)
   );

   mfq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .NUM_LEVELS  (NUM_LEVELS),
      .IW          (IW),
      .LW          (LW),
      .AW          (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_action  (req_chan.action),
      .req_job_id  (req_chan.job_id),
      .req_burst   (req_chan.burst),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .alu_res     (alu_res)
   );

   assign rsp_chan.status    = rsp_data.status;
   assign rsp_chan.served_id = rsp_data.served_id;
   assign rsp_chan.level     = rsp_data.level;
   assign rsp_chan.ran       = rsp_data.ran;
   assign rsp_chan.left      = rsp_data.left;
   assign rsp_chan.demotions = rsp_data.demotions;
   assign rsp_chan.finished  = rsp_data.finished;
   assign rsp_chan.last      = rsp_data.last;

endmodule

[src/mfq_csr.sv]
// ----------------------------------------------------------------------------
// mfq_csr
// APB register block holding the slice length.
// ----------------------------------------------------------------------------
module mfq_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [15:0] slice_len
);
   import mfq_pkg::*;

   logic [15:0] slice_ff;
   logic [15:0] slice_in;
   logic        wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite
                  && (csr_paddr[2] == CSR_IDX_SLICE);

   always_comb begin
      slice_in = slice_ff;
      if (wr_en) begin
         slice_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff <= SLICE_LEN_RESET;
      end else begin
         slice_ff <= slice_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_SLICE) ? {16'd0, slice_ff} : 32'd0;
   assign csr_pready = 1'b1;
   assign slice_len  = slice_ff;

endmodule

[src/mfq_store.sv]
// ----------------------------------------------------------------------------
// mfq_store
// Job ring storage for all levels, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfq_store #(
   parameter int ADDR_W = 6,
   parameter int DEPTH  = 48
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  mfq_pkg::job_type    wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output mfq_pkg::job_type    rd_data
);
   import mfq_pkg::*;

   job_type mem [0:DEPTH-1];
   job_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/mfq_alu.sv]
// ----------------------------------------------------------------------------
// mfq_alu
// Shared dispatch unit: run min(remaining, slice), update the demotion count.
// ----------------------------------------------------------------------------
module mfq_alu (
   input  logic [15:0]          slice_len,
   input  mfq_pkg::job_type     job,
   output mfq_pkg::alu_res_type res
);
   import mfq_pkg::*;

   logic [15:0] slice;
   logic [15:0] ran;
   logic [15:0] left;

   always_comb begin
      slice = (slice_len == 16'd0) ? 16'd1 : slice_len;
      ran   = (job.rem < slice) ? job.rem : slice;
      left  = job.rem - ran;
      res.ran  = ran;
      res.left = left;
      res.done = (left == 16'd0);
      if ((left != 16'd0) && (job.dem != COUNT_MAX)) begin
         res.dem = job.dem + 16'd1;
      end else begin
         res.dem = job.dem;
      end
   end

endmodule

[src/mfq_ctrl.sv]
// ----------------------------------------------------------------------------
// mfq_ctrl
// Sequencer: level pointers, admit path, round walk and response register.
// ----------------------------------------------------------------------------
module mfq_ctrl #(
   parameter int QUEUE_DEPTH = mfq_pkg::QUEUE_DEPTH_DEF,
   parameter int NUM_LEVELS  = mfq_pkg::NUM_LEVELS_DEF,
   parameter int IW          = $clog2(QUEUE_DEPTH),
   parameter int LW          = $clog2(NUM_LEVELS),
   parameter int AW          = IW + LW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [7:0]            req_job_id,
   input  logic [15:0]           req_burst,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mfq_pkg::rsp_type      rsp_data,
   output logic                  mem_wr_en,
   output logic [AW-1:0]         mem_wr_addr,
   output mfq_pkg::job_type      mem_wr_data,
   output logic                  mem_rd_en,
   output logic [AW-1:0]         mem_rd_addr,
   input  mfq_pkg::job_type      mem_rd_data,
   input  mfq_pkg::alu_res_type  alu_res
);
   import mfq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [LW-1:0] LVL_LAST = LW'(NUM_LEVELS - 1);
   localparam logic [IW-1:0] PTR_LAST = IW'(QUEUE_DEPTH - 1);

   state_type     state_ff, state_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [IW-1:0] head_ff [NUM_LEVELS];
   logic [IW-1:0] head_in [NUM_LEVELS];
   logic [IW-1:0] tail_ff [NUM_LEVELS];
   logic [IW-1:0] tail_in [NUM_LEVELS];
   logic [CW-1:0] count_ff [NUM_LEVELS];
   logic [CW-1:0] count_in [NUM_LEVELS];
   logic [CW-1:0] total_ff, total_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          out_free;
   logic          req_fire;
   logic [LW-1:0] dst;
   logic [LW-1:0] qsel;
   logic [IW-1:0] q_head;
   logic [IW-1:0] q_tail;
   logic [CW-1:0] q_count;
   logic          q_nonempty;
   logic          later_busy;
   logic          is_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   assign dst  = (lvl_ff == LVL_LAST) ? lvl_ff : LW'(lvl_ff + 1'b1);

   // one pointer set is looked at per cycle: level 0 on admit, the popped
   // level while scanning, the destination level on write back
   always_comb begin
      case (state_ff)
         S_IDLE:  qsel = '0;
         S_EXEC:  qsel = dst;
         default: qsel = lvl_ff;
      endcase
   end

   assign q_head     = head_ff[qsel];
   assign q_tail     = tail_ff[qsel];
   assign q_count    = count_ff[qsel];
   assign q_nonempty = (q_count != '0);

   always_comb begin
      later_busy = 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if ((LW'(i) > lvl_ff) && (count_ff[i] != '0)) begin
            later_busy = 1'b1;
         end
      end
   end

   assign is_last = (lvl_ff == LVL_LAST) || (alu_res.done && !later_busy);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_action == ACT_ROUND)) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (q_nonempty) begin
               state_in = S_EXEC;
            end else if ((lvl_ff == LVL_LAST) && out_free) begin
               state_in = S_IDLE;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = is_last ? S_IDLE : S_SCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath actions
   always_comb begin
      lvl_in       = lvl_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = {qsel, q_tail};
      mem_wr_data  = '{id: req_job_id, rem: req_burst, dem: 16'd0};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = {lvl_ff, q_head};

      case (state_ff)
         S_IDLE: begin
            lvl_in = '0;
            if (req_fire && (req_action == ACT_ADMIT)) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: STAT_REJECTED, served_id: req_job_id, level: 2'd0,
                          ran: 16'd0, left: 16'd0, demotions: 16'd0,
                          finished: 1'b0, last: 1'b1};
               if (total_ff < CW'(QUEUE_DEPTH)) begin
                  mem_wr_en       = 1'b1;
                  tail_in[qsel]   = (q_tail == PTR_LAST) ? '0 : IW'(q_tail + 1'b1);
                  count_in[qsel]  = CW'(q_count + 1'b1);
                  total_in        = CW'(total_ff + 1'b1);
                  rsp_in.status   = STAT_ADMITTED;
                  rsp_in.left     = req_burst;
               end
            end
         end
         S_SCAN: begin
            if (q_nonempty) begin
               mem_rd_en      = 1'b1;
               head_in[qsel]  = (q_head == PTR_LAST) ? '0 : IW'(q_head + 1'b1);
               count_in[qsel] = CW'(q_count - 1'b1);
            end else if (lvl_ff == LVL_LAST) begin
               // nothing dispatched in this round
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: STAT_IDLE, served_id: 8'd0, level: 2'd0,
                             ran: 16'd0, left: 16'd0, demotions: 16'd0,
                             finished: 1'b0, last: 1'b1};
               end
            end else begin
               lvl_in = LW'(lvl_ff + 1'b1);
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: STAT_DISPATCHED, served_id: mem_rd_data.id,
                          level: 2'(lvl_ff), ran: alu_res.ran, left: alu_res.left,
                          demotions: alu_res.dem, finished: alu_res.done,
                          last: is_last};
               lvl_in = dst;
               if (alu_res.done) begin
                  total_in = CW'(total_ff - 1'b1);
               end else begin
                  mem_wr_en      = 1'b1;
                  mem_wr_data    = '{id: mem_rd_data.id, rem: alu_res.left,
                                     dem: alu_res.dem};
                  tail_in[qsel]  = (q_tail == PTR_LAST) ? '0 : IW'(q_tail + 1'b1);
                  count_in[qsel] = CW'(q_count + 1'b1);
               end
            end
         end
         default: begin
            lvl_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lvl_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
